// File: rtl/slsfp_pkg.sv
// Shared definitions for the sync/length/sum frame parser.
// Header bytes, length limits, status codes and the result record.
// No dependencies.
`default_nettype none

package slsfp_pkg;

    localparam int MAX_FRAME_DEF = 256;
    localparam int MIN_FRAME     = 7;
    localparam int POS_W         = 9;

    localparam logic [7:0] HDR0 = 8'h55;
    localparam logic [7:0] HDR1 = 8'hAA;
    localparam logic [7:0] HDR2 = 8'h01;

    typedef enum logic [2:0] {
        ST_IN_FRAME = 3'd0,
        ST_GOOD     = 3'd1,
        ST_BAD_SUM  = 3'd2,
        ST_DROP     = 3'd3,
        ST_BAD_LEN  = 3'd4,
        ST_CLEARED  = 3'd5
    } status_t;

    typedef enum logic [6:0] {
        PH_HUNT   = 7'b000_0001,
        PH_HDR1   = 7'b000_0010,
        PH_HDR2   = 7'b000_0100,
        PH_LEN_HI = 7'b000_1000,
        PH_LEN_LO = 7'b001_0000,
        PH_DATA   = 7'b010_0000,
        PH_LAST   = 7'b100_0000
    } phase_t;

    typedef struct packed {
        status_t          status;
        logic [7:0]       frame_byte;
        logic [POS_W-1:0] byte_position;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/slsfp_parse_core.sv
// Parser state machine: header hunt, length capture, byte count and sum.
// Updates state on each accepted transfer and forms its result combinationally.
// Depends on slsfp_pkg.
`default_nettype none

module slsfp_parse_core
    import slsfp_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_fire,
    input  wire logic       in_cmd,
    input  wire logic [7:0] in_byte,
    output result_t         res
);

    localparam int CW = $clog2(MAX_FRAME + 1);

    phase_t        phase_reg, phase_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    lhi_reg, lhi_next;
    logic [15:0]   flen_reg, flen_next;

    logic [CW-1:0] count_inc;
    logic [CW-1:0] pos_sel;
    logic [7:0]    sum_add;
    logic [15:0]   len_word;
    logic          len_bad;

    assign count_inc = count_reg + CW'(1);
    assign sum_add   = sum_reg + in_byte;
    assign len_word  = {lhi_reg, in_byte};
    assign len_bad   = (len_word < 16'(MIN_FRAME)) || (17'(len_word) > 17'(MAX_FRAME));

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        lhi_next   = lhi_reg;
        flen_next  = flen_reg;
        pos_sel    = count_inc;
        res.status     = ST_IN_FRAME;
        res.frame_byte = in_byte;

        if (in_cmd) begin
            phase_next     = PH_HUNT;
            count_next     = '0;
            sum_next       = '0;
            lhi_next       = '0;
            flen_next      = '0;
            pos_sel        = '0;
            res.status     = ST_CLEARED;
            res.frame_byte = '0;
        end else begin
            case (phase_reg)
                PH_HDR1, PH_HDR2: begin
                    if (in_byte != ((phase_reg == PH_HDR1) ? HDR1 : HDR2)) begin
                        phase_next = PH_HUNT;
                        count_next = '0;
                        sum_next   = '0;
                        pos_sel    = '0;
                        res.status = ST_DROP;
                    end else begin
                        phase_next = (phase_reg == PH_HDR1) ? PH_HDR2 : PH_LEN_HI;
                        count_next = count_inc;
                        sum_next   = sum_add;
                    end
                end
                PH_LEN_HI: begin
                    lhi_next   = in_byte;
                    phase_next = PH_LEN_LO;
                    count_next = count_inc;
                    sum_next   = sum_add;
                end
                PH_LEN_LO: begin
                    flen_next = len_word;
                    if (len_bad) begin
                        phase_next = PH_HUNT;
                        count_next = '0;
                        sum_next   = '0;
                        res.status = ST_BAD_LEN;
                    end else begin
                        phase_next = PH_DATA;
                        count_next = count_inc;
                        sum_next   = sum_add;
                    end
                end
                PH_DATA: begin
                    if (17'(count_inc) == 17'(flen_reg) - 17'd1) begin
                        phase_next = PH_LAST;
                    end
                    count_next = count_inc;
                    sum_next   = sum_add;
                end
                PH_LAST: begin
                    res.status = (sum_add == 8'd0) ? ST_GOOD : ST_BAD_SUM;
                    phase_next = PH_HUNT;
                    count_next = '0;
                    sum_next   = '0;
                end
                default: begin
                    if (in_byte != HDR0) begin
                        phase_next = PH_HUNT;
                        count_next = '0;
                        sum_next   = '0;
                        pos_sel    = '0;
                        res.status = ST_DROP;
                    end else begin
                        phase_next = PH_HDR1;
                        count_next = CW'(1);
                        sum_next   = in_byte;
                        pos_sel    = CW'(1);
                    end
                end
            endcase
        end
        res.byte_position = POS_W'(pos_sel);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
            sum_reg   <= '0;
            lhi_reg   <= '0;
            flen_reg  <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            lhi_reg   <= lhi_next;
            flen_reg  <= flen_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/slsfp_out_reg.sv
// Result register stage with stream handshake towards the consumer.
// Takes a new result whenever empty or being drained in the same cycle.
// Depends on slsfp_pkg.
`default_nettype none

module slsfp_out_reg
    import slsfp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire result_t     in_res,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // frame_byte[7:0], byte_position[16:8], zero pad
    output logic [2:0]       m_tuser    // status
);

    logic    valid_reg;
    result_t res_reg;

    assign in_ready = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, res_reg.byte_position, res_reg.frame_byte};
    assign m_tuser  = res_reg.status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            res_reg <= in_res;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sync_length_sum_frame_parser_unit.sv
// Sync/length/sum frame parser, top level.
// Joins the parser state machine to the result register stage.
// Depends on slsfp_pkg, slsfp_parse_core, slsfp_out_reg.
//
// One received byte per input transfer (s_tuser high clears the parser).
// The parser hunts for 55 AA 01, reads a big-endian total length, counts
// bytes to the end of the frame and checks that the 8-bit sum of all frame
// bytes is zero. Every transfer yields exactly one result transfer with the
// echoed byte (zero on a clear), its frame position and a status. One
// transfer per cycle unless m_tready stalls the full result register, which
// presents each result in the cycle after its transfer. Lengths under 7 or
// above MAX_FRAME are reported as bad length on the second length byte.
`default_nettype none

module sync_length_sum_frame_parser_unit
    import slsfp_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte
    input  wire logic        s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // frame_byte[7:0], byte_position[16:8], zero pad
    output logic [2:0]       m_tuser    // status
);

    logic    fire;
    result_t res;

    assign fire = s_tvalid && s_tready;

    slsfp_parse_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (fire),
        .in_cmd  (s_tuser),
        .in_byte (s_tdata),
        .res     (res)
    );

    slsfp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_res   (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
